>>> rtl/core/generational_slot_allocator_macros.svh
// Assertion macros shared by the generational slot allocator RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef GENERATIONAL_SLOT_ALLOCATOR_MACROS_SVH
`define GENERATIONAL_SLOT_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
`define GSA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define GSA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define GSA_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define GSA_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

>>> rtl/core/gsa_pkg.sv
// Package for the generational slot allocator: sizes, opcodes, status codes
// and the structs passed between its modules. No dependencies.
package gsa_pkg;

   localparam int SLOT_COUNT = 256;
   localparam int GEN_BITS   = 32;

   localparam int IDX_W = $clog2(SLOT_COUNT);
   localparam int CNT_W = $clog2(SLOT_COUNT + 1);

   localparam int OPCODE_W = 3;
   localparam int INDEX_W  = 8;
   localparam int HANDLE_W = 64;
   localparam int HALF_W   = 32;
   localparam int STATUS_W = 2;
   localparam int LIVE_W   = 9;

   localparam logic [GEN_BITS-1:0] GEN_MAX   = '1;
   localparam logic [GEN_BITS-1:0] GEN_FIRST = GEN_BITS'(1);

   localparam logic [OPCODE_W-1:0] OP_ALLOC   = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_RELEASE = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_HANDLE  = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_CHECK   = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_CLEAR   = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

   localparam int SCAN_W      = (SLOT_COUNT < 64) ? SLOT_COUNT : 64;
   localparam int SCAN_IDX_W  = $clog2(SCAN_W);
   localparam int CHUNK_COUNT = (SLOT_COUNT + SCAN_W - 1) / SCAN_W;
   localparam int CHUNK_W     = (CHUNK_COUNT > 1) ? $clog2(CHUNK_COUNT) : 1;
   localparam int PAD_COUNT   = CHUNK_COUNT * SCAN_W;
   localparam int POS_W       = $clog2(PAD_COUNT + 1);

   typedef struct packed {
      logic             start;
      logic [CNT_W-1:0] high_water;
   } gsa_scan_ctrl_type;

   typedef struct packed {
      logic             done;
      logic             found;
      logic [IDX_W-1:0] slot;
   } gsa_scan_stat_type;

   typedef struct packed {
      logic                en;
      logic                we;
      logic [IDX_W-1:0]    addr;
      logic [GEN_BITS-1:0] wdata;
   } gsa_ram_req_type;

endpackage

>>> rtl/core/gsa_req_if.sv
// Request channel of the generational slot allocator: valid, ready and payload.
// Depends on gsa_pkg for the field widths.
interface gsa_req_if import gsa_pkg::*; ();

   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [INDEX_W-1:0]  slot_index;
   logic [HANDLE_W-1:0] handle_in;

   modport source (output valid, opcode, slot_index, handle_in, input ready);
   modport sink   (input valid, opcode, slot_index, handle_in, output ready);

endinterface

>>> rtl/core/gsa_rsp_if.sv
// Response channel of the generational slot allocator: valid, ready and payload.
// Depends on gsa_pkg for the field widths.
interface gsa_rsp_if import gsa_pkg::*; ();

   logic                valid;
   logic                ready;
   logic [INDEX_W-1:0]  result_index;
   logic [HANDLE_W-1:0] handle_out;
   logic [STATUS_W-1:0] status;
   logic [LIVE_W-1:0]   live_count;

   modport source (output valid, result_index, handle_out, status, live_count, input ready);
   modport sink   (input valid, result_index, handle_out, status, live_count, output ready);

endinterface

>>> rtl/core/generational_slot_allocator.sv
// Top level of the generational slot allocator: request sequencer, active bits,
// counters and response register. Depends on gsa_pkg, gsa_scan, gsa_gen_ram,
// the channel interfaces and the macros.
//
// The allocator works on one request at a time and holds ready low until its
// response has been loaded into the output register; a waiting response does
// not stop the next request from being taken. Clear, unknown opcodes and a
// release, handle-of-index or check-handle on a slot that is not live go from
// decode straight to the response; release, handle-of-index and check-handle
// on a live slot first read the single-port generation memory; allocate runs
// the free-slot search, which examines 64 active bits per cycle below the
// high-water mark, and a reused slot then needs its generation read. Reset
// clears the active bits, and the generation memory needs no clearing pass.
`include "generational_slot_allocator_macros.svh"

module generational_slot_allocator import gsa_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   gsa_req_if.sink   req_chan,
   gsa_rsp_if.source rsp_chan
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_READ   = 3'd3;
   localparam logic [2:0] S_DONE   = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [OPCODE_W-1:0]   op_ff, op_in;
   logic [INDEX_W-1:0]    sidx_ff, sidx_in;
   logic [HANDLE_W-1:0]   hin_ff, hin_in;
   logic [IDX_W-1:0]      pick_ff, pick_in;
   logic [SLOT_COUNT-1:0] active_ff, active_in;
   logic [CNT_W-1:0]      high_water_ff, high_water_in;
   logic [CNT_W-1:0]      active_total_ff, active_total_in;
   logic [INDEX_W-1:0]    res_idx_ff, res_idx_in;
   logic [HANDLE_W-1:0]   res_handle_ff, res_handle_in;
   logic [STATUS_W-1:0]   res_status_ff, res_status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0]    rsp_idx_ff, rsp_idx_in;
   logic [HANDLE_W-1:0]   rsp_handle_ff, rsp_handle_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [LIVE_W-1:0]     rsp_live_ff, rsp_live_in;

   gsa_scan_ctrl_type     scan_ctrl;
   gsa_scan_stat_type     scan_stat;
   gsa_ram_req_type       ram_req;
   logic [GEN_BITS-1:0]   ram_rdata;

   logic                  req_fire;
   logic                  rsp_free;
   logic [HALF_W-1:0]     hidx;
   logic                  sidx_live;
   logic                  hidx_live;
   logic                  sel_live;
   logic [IDX_W-1:0]      slot_sel;

   gsa_scan u_scan (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (scan_ctrl),
      .active (active_ff),
      .stat   (scan_stat)
   );

   gsa_gen_ram u_gen_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (ram_rdata)
   );

   assign req_chan.ready        = (state_ff == S_IDLE);
   assign req_fire              = req_chan.valid && req_chan.ready;
   assign rsp_free              = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.result_index = rsp_idx_ff;
   assign rsp_chan.handle_out   = rsp_handle_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.live_count   = rsp_live_ff;

   assign hidx      = hin_ff[HALF_W-1:0];
   assign sidx_live = (HALF_W'(sidx_ff) < HALF_W'(high_water_ff)) && active_ff[IDX_W'(sidx_ff)];
   assign hidx_live = (hidx < HALF_W'(high_water_ff)) && active_ff[IDX_W'(hidx)];
   assign sel_live  = (op_ff == OP_CHECK) ? hidx_live : sidx_live;
   assign slot_sel  = (op_ff == OP_CHECK) ? IDX_W'(hidx) : IDX_W'(sidx_ff);

   always_comb begin
      state_in             = state_ff;
      op_in                = op_ff;
      sidx_in              = sidx_ff;
      hin_in               = hin_ff;
      pick_in              = pick_ff;
      active_in            = active_ff;
      high_water_in        = high_water_ff;
      active_total_in      = active_total_ff;
      res_idx_in           = res_idx_ff;
      res_handle_in        = res_handle_ff;
      res_status_in        = res_status_ff;
      rsp_valid_in         = rsp_valid_ff;
      rsp_idx_in           = rsp_idx_ff;
      rsp_handle_in        = rsp_handle_ff;
      rsp_status_in        = rsp_status_ff;
      rsp_live_in          = rsp_live_ff;
      scan_ctrl.start      = 1'b0;
      scan_ctrl.high_water = high_water_ff;
      ram_req              = '0;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in    = req_chan.opcode;
               sidx_in  = req_chan.slot_index;
               hin_in   = req_chan.handle_in;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            res_idx_in    = '0;
            res_handle_in = '0;
            res_status_in = ST_OK;
            case (op_ff) inside
               OP_ALLOC: begin
                  scan_ctrl.start = 1'b1;
                  state_in        = S_SCAN;
               end
               OP_RELEASE, OP_HANDLE, OP_CHECK: begin
                  if (sel_live) begin
                     ram_req.en   = 1'b1;
                     ram_req.addr = slot_sel;
                     pick_in      = slot_sel;
                     state_in     = S_READ;
                  end else begin
                     res_status_in = ST_INVALID;
                     state_in      = S_DONE;
                  end
               end
               OP_CLEAR: begin
                  active_in       = '0;
                  high_water_in   = '0;
                  active_total_in = '0;
                  state_in        = S_DONE;
               end
               default: begin
                  res_status_in = ST_INVALID;
                  state_in      = S_DONE;
               end
            endcase
         end
         S_SCAN: begin
            if (scan_stat.done) begin
               if (scan_stat.found) begin
                  ram_req.en   = 1'b1;
                  ram_req.addr = scan_stat.slot;
                  pick_in      = scan_stat.slot;
                  state_in     = S_READ;
               end else if (high_water_ff < CNT_W'(SLOT_COUNT)) begin
                  // A fresh slot opens with its first generation.
                  ram_req.en    = 1'b1;
                  ram_req.we    = 1'b1;
                  ram_req.addr  = IDX_W'(high_water_ff);
                  ram_req.wdata = GEN_FIRST;
                  active_in[IDX_W'(high_water_ff)] = 1'b1;
                  high_water_in   = high_water_ff + CNT_W'(1);
                  active_total_in = active_total_ff + CNT_W'(1);
                  res_idx_in      = INDEX_W'(high_water_ff);
                  res_handle_in   = {HALF_W'(GEN_FIRST), HALF_W'(high_water_ff)};
                  state_in        = S_DONE;
               end else begin
                  res_status_in = ST_FULL;
                  state_in      = S_DONE;
               end
            end
         end
         S_READ: begin
            case (op_ff)
               OP_ALLOC: begin
                  active_in[pick_ff] = 1'b1;
                  active_total_in    = active_total_ff + CNT_W'(1);
                  res_idx_in         = INDEX_W'(pick_ff);
                  res_handle_in      = {HALF_W'(ram_rdata), HALF_W'(pick_ff)};
               end
               OP_RELEASE: begin
                  ram_req.en         = 1'b1;
                  ram_req.we         = 1'b1;
                  ram_req.addr       = pick_ff;
                  ram_req.wdata      = (ram_rdata == GEN_MAX) ? GEN_FIRST
                                     : ram_rdata + GEN_BITS'(1);
                  active_in[pick_ff] = 1'b0;
                  active_total_in    = active_total_ff - CNT_W'(1);
                  res_idx_in         = INDEX_W'(pick_ff);
               end
               OP_HANDLE: begin
                  res_idx_in    = INDEX_W'(pick_ff);
                  res_handle_in = {HALF_W'(ram_rdata), HALF_W'(pick_ff)};
               end
               default: begin
                  if (HALF_W'(ram_rdata) == hin_ff[HANDLE_W-1:HALF_W]) begin
                     res_idx_in    = INDEX_W'(pick_ff);
                     res_handle_in = hin_ff;
                  end else begin
                     res_status_in = ST_INVALID;
                  end
               end
            endcase
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_idx_in    = res_idx_ff;
               rsp_handle_in = res_handle_ff;
               rsp_status_in = res_status_ff;
               rsp_live_in   = LIVE_W'(active_total_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         active_ff       <= '0;
         high_water_ff   <= '0;
         active_total_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         active_ff       <= active_in;
         high_water_ff   <= high_water_in;
         active_total_ff <= active_total_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      sidx_ff       <= sidx_in;
      hin_ff        <= hin_in;
      pick_ff       <= pick_in;
      res_idx_ff    <= res_idx_in;
      res_handle_ff <= res_handle_in;
      res_status_ff <= res_status_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_status_ff <= rsp_status_in;
      rsp_live_ff   <= rsp_live_in;
   end

   `GSA_ASSERT_SAME(a_total_below_water, clock, reset, 1'b1, active_total_ff <= high_water_ff, "More slots are active than have ever been opened.")
   `GSA_ASSERT_SAME(a_full_means_full, clock, reset, (state_ff == S_DONE) && (res_status_ff == ST_FULL), (high_water_ff == CNT_W'(SLOT_COUNT)) && (active_total_ff == CNT_W'(SLOT_COUNT)), "Full was reported while a slot was still free.")
   `GSA_ASSERT_SAME(a_read_issued, clock, reset, state_ff == S_READ, $past(ram_req.en && !ram_req.we), "Generation data was used without a read in the previous cycle.")

endmodule

>>> rtl/core/gsa_gen_ram.sv
// Single-port generation store with registered read data.
// Depends on gsa_pkg for its depth, width and request struct.
module gsa_gen_ram import gsa_pkg::*; (
   input  logic                clock,
   input  gsa_ram_req_type     ram_req,
   output logic [GEN_BITS-1:0] rd_data
);

   logic [GEN_BITS-1:0] mem_ff [SLOT_COUNT];
   logic [GEN_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.en) begin
         if (ram_req.we) begin
            mem_ff[ram_req.addr] <= ram_req.wdata;
         end else begin
            rd_data_ff <= mem_ff[ram_req.addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/gsa_scan.sv
// Free-slot search: walks the active bits one chunk per cycle and returns the
// lowest inactive slot below the high-water mark. Depends on gsa_pkg and the macros.
`include "generational_slot_allocator_macros.svh"

module gsa_scan import gsa_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  gsa_scan_ctrl_type     ctrl,
   input  logic [SLOT_COUNT-1:0] active,
   output gsa_scan_stat_type     stat
);

   logic               busy_ff, busy_in;
   logic [CHUNK_W-1:0] chunk_ff, chunk_in;

   logic [PAD_COUNT-1:0]  padded;
   logic [SCAN_W-1:0]     window;
   logic [SCAN_W-1:0]     free;
   logic [POS_W-1:0]      base;
   logic [POS_W-1:0]      next_base;
   logic [SCAN_IDX_W-1:0] hit_lane;
   logic                  hit;
   logic                  last;

   always_comb begin
      padded    = PAD_COUNT'(active);
      window    = padded[chunk_ff * SCAN_W +: SCAN_W];
      base      = POS_W'(chunk_ff) * POS_W'(SCAN_W);
      next_base = base + POS_W'(SCAN_W);
      for (int j = 0; j < SCAN_W; j++) begin
         free[j] = !window[j] && ((base + POS_W'(j)) < POS_W'(ctrl.high_water));
      end
      hit      = 1'b0;
      hit_lane = '0;
      for (int j = SCAN_W - 1; j >= 0; j--) begin
         if (free[j]) begin
            hit      = 1'b1;
            hit_lane = SCAN_IDX_W'(j);
         end
      end
      last = (chunk_ff == CHUNK_W'(CHUNK_COUNT - 1))
         || (next_base >= POS_W'(ctrl.high_water));
   end

   assign stat.done  = busy_ff && (hit || last);
   assign stat.found = busy_ff && hit;
   assign stat.slot  = IDX_W'(base + POS_W'(hit_lane));

   always_comb begin
      busy_in  = busy_ff;
      chunk_in = chunk_ff;
      if (ctrl.start) begin
         busy_in  = 1'b1;
         chunk_in = '0;
      end else if (busy_ff) begin
         if (stat.done) begin
            busy_in = 1'b0;
         end else begin
            chunk_in = chunk_ff + CHUNK_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         chunk_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         chunk_ff <= chunk_in;
      end
   end

   `GSA_ASSERT_SAME(a_found_is_free, clock, reset, stat.found, !active[stat.slot] && (CNT_W'(stat.slot) < ctrl.high_water), "Scan returned a slot that is active or above the high-water mark.")
   `GSA_ASSERT_NEXT(a_done_ends_scan, clock, reset, stat.done, !busy_ff, "Scan kept running after it had finished.")
   `GSA_ASSERT_SAME(a_no_restart, clock, reset, ctrl.start, !busy_ff, "A scan was started while another was still running.")

endmodule
